// ===== rtl/ready_to_drive_safety_sequencer_defines.svh =====
// Assertion macros used by the ready to drive sequencer step module.
`ifndef READY_TO_DRIVE_SAFETY_SEQUENCER_DEFINES_SVH
`define READY_TO_DRIVE_SAFETY_SEQUENCER_DEFINES_SVH

// Clocked on clk, quiet while rst_n is low.
`define RTDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked on clk, checked during reset as well.
`define RTDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rtds_pkg.sv =====
// Types and constants of the ready to drive safety sequencer.
package rtds_pkg;

  // Vehicle state ladder codes, compared as levels
  typedef logic [2:0] rtds_state_t;
  localparam rtds_state_t ST_IDLE       = 3'd0;
  localparam rtds_state_t ST_LV_ON      = 3'd1;
  localparam rtds_state_t ST_PRECHARGED = 3'd2;
  localparam rtds_state_t ST_ENABLED    = 3'd3;
  localparam rtds_state_t ST_SOUND      = 3'd4;
  localparam rtds_state_t ST_POWER      = 3'd5;
  localparam rtds_state_t ST_SOFT_FAULT = 3'd6;

  // Configuration register indexes
  typedef logic [2:0] rtds_cfg_idx_t;
  localparam rtds_cfg_idx_t CFG_START_BRAKE_LEVEL      = 3'd0;
  localparam rtds_cfg_idx_t CFG_BRAKE_LEVEL            = 3'd1;
  localparam rtds_cfg_idx_t CFG_THROTTLE_RELEASE_LEVEL = 3'd2;
  localparam rtds_cfg_idx_t CFG_THROTTLE_ENGAGE_LEVEL  = 3'd3;
  localparam rtds_cfg_idx_t CFG_SOUND_TICKS            = 3'd4;

  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [11:0] START_BRAKE_LEVEL_RST      = 12'd2500;
  localparam logic [11:0] BRAKE_LEVEL_RST            = 12'd2000;
  localparam logic [11:0] THROTTLE_RELEASE_LEVEL_RST = 12'd584;
  localparam logic [11:0] THROTTLE_ENGAGE_LEVEL_RST  = 12'd947;
  localparam logic [15:0] SOUND_TICKS_RST            = 16'd2500;
  localparam logic [15:0] SOUND_TIMER_RST            = 16'd2500;

  typedef struct packed {
    logic [11:0] start_brake_level;
    logic [11:0] brake_level;
    logic [11:0] throttle_release_level;
    logic [11:0] throttle_engage_level;
    logic [15:0] sound_ticks;
  } rtds_cfg_t;

  typedef struct packed {
    logic        precharge_done;
    logic        enable_on;
    logic [11:0] brake_pressure;
    logic [11:0] throttle_sample;
    logic        bms_fault;
    logic        imd_fault;
    logic        bspd_fault;
  } rtds_in_t;

  typedef struct packed {
    logic [2:0] vehicle_state;
    logic       drive_enable;
    logic       sound_enable;
    logic       brake_throttle_enable;
    logic       pedal_enable;
    logic       brake_light;
    logic       bms_status;
    logic       imd_status;
    logic       bspd_status;
  } rtds_out_t;

endpackage

// ===== rtl/rtds_cfg_regs.sv =====
// Configuration register file of the ready to drive sequencer.
module rtds_cfg_regs
  import rtds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  rtds_cfg_idx_t         cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output rtds_cfg_t             cfg
);

  rtds_cfg_t cfg_r;
  rtds_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_BRAKE_LEVEL:      cfg_nxt.start_brake_level      = cfg_wdata[11:0];
        CFG_BRAKE_LEVEL:            cfg_nxt.brake_level            = cfg_wdata[11:0];
        CFG_THROTTLE_RELEASE_LEVEL: cfg_nxt.throttle_release_level = cfg_wdata[11:0];
        CFG_THROTTLE_ENGAGE_LEVEL:  cfg_nxt.throttle_engage_level  = cfg_wdata[11:0];
        CFG_SOUND_TICKS:            cfg_nxt.sound_ticks            = cfg_wdata[15:0];
        default:                    cfg_nxt = cfg_r; // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_brake_level      <= START_BRAKE_LEVEL_RST;
      cfg_r.brake_level            <= BRAKE_LEVEL_RST;
      cfg_r.throttle_release_level <= THROTTLE_RELEASE_LEVEL_RST;
      cfg_r.throttle_engage_level  <= THROTTLE_ENGAGE_LEVEL_RST;
      cfg_r.sound_ticks            <= SOUND_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/rtds_step.sv =====
// Vehicle state registers and the per-tick update of the sequencer.
`include "ready_to_drive_safety_sequencer_defines.svh"

module rtds_step
  import rtds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  rtds_in_t  item,
  input  rtds_cfg_t cfg,
  output rtds_out_t result
);

  rtds_state_t state_r, state_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic        latch_r, latch_nxt;
  logic        de_r, de_nxt;
  logic        se_r, se_nxt;
  logic        bte_r, bte_nxt;
  logic        pe_r, pe_nxt;

  always_comb begin
    logic fault;
    logic brake_pressed;
    logic [15:0] t;
    brake_pressed = item.brake_pressure > cfg.brake_level;
    state_nxt = state_r;
    t         = timer_r;
    latch_nxt = latch_r;
    de_nxt    = de_r;
    se_nxt    = se_r;
    bte_nxt   = bte_r;
    pe_nxt    = pe_r;
    fault     = 1'b0;

    if (item.precharge_done) begin
      if (state_nxt < ST_PRECHARGED) state_nxt = ST_PRECHARGED;
      if (item.enable_on) begin
        if (state_nxt < ST_ENABLED) state_nxt = ST_ENABLED;
        if (item.brake_pressure >= cfg.start_brake_level && state_nxt == ST_ENABLED) begin
          t         = cfg.sound_ticks;
          state_nxt = ST_SOUND;
          de_nxt    = 1'b1;
          se_nxt    = 1'b1;
          bte_nxt   = 1'b1;
          pe_nxt    = 1'b1;
        end
        if (t == '0 && state_nxt >= ST_SOUND) begin
          se_nxt = 1'b0;
          if (state_nxt < ST_POWER) state_nxt = ST_POWER;
        end
      end else begin
        state_nxt = ST_PRECHARGED;
        de_nxt    = 1'b0;
      end
    end

    if (t == '0) se_nxt = 1'b0;

    if (state_nxt >= ST_SOUND) begin
      if (latch_r) begin
        if (item.throttle_sample <= cfg.throttle_release_level) latch_nxt = 1'b0;
        else fault = 1'b1;
      end else if (brake_pressed && item.throttle_sample > cfg.throttle_engage_level) begin
        latch_nxt = 1'b1;
        fault     = 1'b1;
      end
      if (fault) begin
        bte_nxt   = 1'b0;
        pe_nxt    = 1'b0;
        state_nxt = ST_SOFT_FAULT;
      end else if (state_nxt == ST_SOFT_FAULT) begin
        state_nxt = ST_POWER;
        bte_nxt   = 1'b1;
        pe_nxt    = 1'b1;
      end
    end

    if (item.bms_fault || item.imd_fault) begin
      state_nxt = ST_LV_ON;
      de_nxt    = 1'b0;
      se_nxt    = 1'b0;
    end

    // count down, hold at zero
    timer_nxt = (t != '0) ? t - 16'd1 : t;

    result.vehicle_state         = state_nxt;
    result.drive_enable          = de_nxt;
    result.sound_enable          = se_nxt;
    result.brake_throttle_enable = bte_nxt;
    result.pedal_enable          = pe_nxt;
    result.brake_light           = brake_pressed;
    result.bms_status            = item.bms_fault;
    result.imd_status            = item.imd_fault;
    result.bspd_status           = item.bspd_fault;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      timer_r <= SOUND_TIMER_RST;
      latch_r <= 1'b0;
      de_r    <= 1'b0;
      se_r    <= 1'b0;
      bte_r   <= 1'b0;
      pe_r    <= 1'b0;
    end else if (adv) begin
      state_r <= state_nxt;
      timer_r <= timer_nxt;
      latch_r <= latch_nxt;
      de_r    <= de_nxt;
      se_r    <= se_nxt;
      bte_r   <= bte_nxt;
      pe_r    <= pe_nxt;
    end
  end

  `RTDS_ASSERT(a_hard_fault_lv_on, adv && (item.bms_fault || item.imd_fault) |=> state_r == ST_LV_ON, "hard fault did not force LV on")
  `RTDS_ASSERT(a_drive_needs_sound, de_r |-> state_r >= ST_SOUND, "drive enable high below sound state")
  `RTDS_ASSERT(a_idle_holds, !adv |=> $stable(state_r) && $stable(timer_r) && $stable(latch_r), "state moved without a transaction")
  `RTDS_ASSERT_ALWAYS(a_reset_state, !rst_n |=> state_r == ST_IDLE && !de_r && !se_r, "reset did not clear the ladder")

endmodule

// ===== rtl/ready_to_drive_safety_sequencer.sv =====
// Top level of the ready to drive safety sequencer.
// Each input transaction is one millisecond tick; each tick yields exactly one result
// transaction. A tick enters an input register, is evaluated against the vehicle state
// combinationally and lands in the result register; one tick is taken every cycle while
// the result side keeps up. The result register and the input register form two stages,
// so a new tick is still taken while one finished result waits. Configuration writes
// land in the next cycle and must only be made while no tick is in flight. The state,
// sound timer and enables reset to idle, 2500 and off.
module ready_to_drive_safety_sequencer
  import rtds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rtds_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rtds_out_t             out_data,
  input  logic                  cfg_we,
  input  rtds_cfg_idx_t         cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  rtds_cfg_t cfg;
  rtds_in_t  item_r;
  logic      item_valid_r;
  rtds_out_t result;
  rtds_out_t out_r;
  logic      out_valid_r;
  logic      adv;
  logic      in_take;

  rtds_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // advance the held tick when the result register is free or draining
  assign adv      = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = item_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  rtds_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_take) item_valid_r <= 1'b1;
      else if (adv) item_valid_r <= 1'b0;
      if (adv) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) item_r <= in_data;
    if (adv) out_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
